// ===== design/akf_pkg.sv =====
// Shared types, constants and arithmetic helpers for the altitude Kalman filter.
package akf_pkg;

    // Fixed-point formats.
    localparam int COV_FRAC       = 24;
    localparam int DEF_FRAC_BITS  = 16;
    localparam logic [31:0] COV_ONE = 32'h0100_0000;

    // Configuration reset values.
    localparam logic [31:0] RST_PNA = 32'd3277;
    localparam logic [31:0] RST_PNV = 32'd6554;
    localparam logic [31:0] RST_MN  = 32'd52429;
    localparam logic [15:0] RST_GAP = 16'd200;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PNA = 2'd0;
    localparam logic [1:0] CFG_PNV = 2'd1;
    localparam logic [1:0] CFG_MN  = 2'd2;
    localparam logic [1:0] CFG_GAP = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_SEEDED  = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_ZERO    = 3'd2;
    localparam logic [2:0] ST_GAP     = 3'd3;
    localparam logic [2:0] ST_BADVAR  = 3'd4;
    localparam logic [2:0] ST_RESTART = 3'd5;

    // Divider geometry: numerator bits, also the number of iterations.
    localparam int DIV_NW = 56;
    localparam logic [5:0] DIV_STEPS = 6'(DIV_NW);

    // Time step: elapsed * 2^24 / 1000 equals elapsed * 16777 plus
    // (27 * elapsed + 62) / 125, the last quotient taken by a reciprocal
    // multiply and a 28-bit shift (exact for elapsed below 2^16).
    localparam logic [14:0] DT_WHOLE = 15'd16777;
    localparam logic [4:0]  DT_REM   = 5'd27;
    localparam logic [5:0]  DT_BIAS  = 6'd62;
    localparam logic [21:0] DT_RECIP = 22'd2147484;

    typedef struct packed {
        logic               action;
        logic signed [31:0] baro_altitude;
        logic signed [31:0] measured_accel;
        logic        [31:0] sample_time_ms;
    } t_in;

    typedef struct packed {
        logic signed [31:0] altitude_estimate;
        logic signed [31:0] velocity_estimate;
        logic signed [31:0] peak_altitude;
        logic        [2:0]  status;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_DT, S_DT2,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
        S_K0, S_K1,
        S_M10, S_M11, S_M12, S_M13, S_M14, S_M15, S_M16,
        S_OUT
    } t_state;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Magnitude of a 34-bit signed multiplier operand.
    function automatic logic [32:0] mag34(input logic signed [33:0] a);
        logic signed [33:0] n;
        n = -a;
        return a[33] ? n[32:0] : a[32:0];
    endfunction

    // Clamp an unsigned quotient to a positive 32-bit gain and apply the sign.
    function automatic logic signed [31:0] gain_fix(input logic [DIV_NW-1:0] q,
                                                    input logic neg);
        logic signed [31:0] v;
        v = (q > DIV_NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
        return neg ? -v : v;
    endfunction

endpackage

// ===== design/altitude_kalman_filter_top.sv =====
// Two-state altitude and velocity Kalman filter with a shared multiplier and divider.
//
//  channel   direction  handshake                      payload
//  -------   ---------  -----------------------------  -------------------------
//  config    in         i_cfg_we                       i_cfg_idx, i_cfg_data
//  sample    in         i_in_valid / o_in_stall        i_in_item (t_in)
//  result    out        o_out_valid / i_out_stall      o_out_item (t_out)
//
// Restart, seed, zero-step and gap items go from acceptance straight to the result wait.
// A filtered item first takes the time step by a constant reciprocal (S_DT, S_DT2),
// then runs two 56-bit divisions on the shared restoring divider (the gains) and
// twelve products on one shared 33x33 multiplier, each product registered before
// it is rounded and summed. A bad-variance item ends at the variance check, before
// the divisions. Reset is synchronous and active low;
// it restores the state and registers.
// The block stalls new items from acceptance until its result has been taken.
module altitude_kalman_filter_top #(
    parameter int FRAC_BITS = akf_pkg::DEF_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  akf_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output akf_pkg::t_out o_out_item
);
    import akf_pkg::*;

    localparam int NSH = COV_FRAC - FRAC_BITS;

    // Configuration registers.
    logic [31:0] r_pna, r_pnv, r_mn;
    logic [15:0] r_gap;

    // Filter state.
    logic signed [31:0] r_alt, r_vel, r_peak;
    logic        [31:0] r_last;
    logic signed [31:0] r_cov [4];
    logic               r_seeded;
    logic        [2:0]  r_status;

    // Sequencer.
    t_state r_state, n_state;

    // Working registers.
    logic signed [31:0] r_meas, r_accel;
    logic        [31:0] r_dt;
    logic signed [31:0] r_ad, r_ap, r_vp, r_t, r_inn;
    logic signed [31:0] r_p00, r_p01, r_p10, r_p11, r_k0, r_k1;
    logic signed [63:0] r_acc;

    // Time step conversion.
    logic        [15:0] r_elap;
    logic        [20:0] r_dn;
    logic        [30:0] r_dint;
    logic        [42:0] w_dprod;

    // Shared multiplier.
    logic        [65:0] r_prod;
    logic               r_psign, r_psh;
    logic signed [33:0] w_ma, w_mb;
    logic               w_msh;
    logic        [65:0] w_rnd;
    logic signed [63:0] w_mmag, w_mr;

    // Shared divider.
    logic [DIV_NW-1:0] r_dnum;
    logic [63:0]       r_dden, r_drem;
    logic [5:0]        r_dcnt;
    logic [63:0]       w_trial;
    logic              w_ge;

    logic               w_accept;
    logic        [31:0] w_elapsed;
    logic signed [63:0] w_qa, w_qv, w_r, w_s;
    logic signed [33:0] w_onek0, w_dt34;

    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_elapsed = i_in_item.sample_time_ms - r_last;
    assign w_qa      = $signed({32'd0, r_pna} << NSH);
    assign w_qv      = $signed({32'd0, r_pnv} << NSH);
    assign w_r       = $signed({32'd0, r_mn} << NSH);
    assign w_s       = 64'(r_p00) + w_r;
    assign w_onek0   = $signed({2'b00, COV_ONE}) - 34'(r_k0);
    assign w_dt34    = $signed({2'b00, r_dt});
    assign w_dprod   = 43'(r_dn) * 43'(DT_RECIP);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_item  = '{altitude_estimate: r_alt, velocity_estimate: r_vel,
                           peak_altitude: r_peak, status: r_status};

    // Multiplier operand selection per sequencer step.
    always_comb begin
        w_ma  = '0;
        w_mb  = w_dt34;
        w_msh = 1'b0;
        unique case (r_state)
            S_M1:  w_ma = 34'(r_accel);
            S_M2:  w_ma = 34'(r_vel);
            S_M3: begin
                w_ma  = 34'(r_ad);
                w_msh = 1'b1;
            end
            S_M4:  w_ma = 34'(r_cov[2]) + 34'(r_cov[1]);
            S_M5:  w_ma = 34'(r_cov[3]);
            S_M7:  w_ma = 34'(r_t);
            S_M10: begin
                w_ma = 34'(r_k0);
                w_mb = 34'(r_inn);
            end
            S_M11: begin
                w_ma = 34'(r_k1);
                w_mb = 34'(r_inn);
            end
            S_M12: begin
                w_ma = w_onek0;
                w_mb = 34'(r_p00);
            end
            S_M13: begin
                w_ma = w_onek0;
                w_mb = 34'(r_p01);
            end
            S_M14: begin
                w_ma = 34'(r_k1);
                w_mb = 34'(r_p00);
            end
            S_M15: begin
                w_ma = 34'(r_k1);
                w_mb = 34'(r_p01);
            end
            default: w_ma = '0;
        endcase
    end

    // Registered magnitude product, then round to nearest and restore the sign.
    always_ff @(posedge i_clk) begin
        r_prod  <= 66'(mag34(w_ma)) * 66'(mag34(w_mb));
        r_psign <= w_ma[33] ^ w_mb[33];
        r_psh   <= w_msh;
    end

    assign w_rnd  = r_psh ? ((r_prod + (66'd1 << 24)) >> 25)
                          : ((r_prod + (66'd1 << 23)) >> 24);
    assign w_mmag = $signed(w_rnd[63:0]);
    assign w_mr   = r_psign ? -w_mmag : w_mmag;

    // Restoring divider, one quotient bit per cycle shifted into the numerator.
    assign w_trial = {r_drem[62:0], r_dnum[DIV_NW-1]};
    assign w_ge    = (w_trial >= r_dden);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (r_state == S_M9) begin
            r_dnum <= DIV_NW'({mag34(34'(r_p00)), 24'd0}) + DIV_NW'(w_s >>> 1);
            r_dden <= w_s;
            r_drem <= '0;
            r_dcnt <= DIV_STEPS;
        end else if (r_state == S_K0 && r_dcnt == '0) begin
            r_dnum <= DIV_NW'({mag34(34'(r_p10)), 24'd0}) + DIV_NW'(r_dden >> 1);
            r_drem <= '0;
            r_dcnt <= DIV_STEPS;
        end else if (r_dcnt != '0) begin
            r_drem <= w_ge ? (w_trial - r_dden) : w_trial;
            r_dnum <= {r_dnum[DIV_NW-2:0], w_ge};
            r_dcnt <= r_dcnt - 6'd1;
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next step of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_item.action || !r_seeded || w_elapsed == '0 ||
                        w_elapsed > {16'd0, r_gap}) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_DT;
                    end
                end
            end
            S_DT:  n_state = S_DT2;
            S_DT2: n_state = S_M1;
            S_M1:  n_state = S_M2;
            S_M2:  n_state = S_M3;
            S_M3:  n_state = S_M4;
            S_M4:  n_state = S_M5;
            S_M5:  n_state = S_M6;
            S_M6:  n_state = S_M7;
            S_M7:  n_state = S_M8;
            S_M8:  n_state = S_M9;
            S_M9:  n_state = (w_s <= 64'sd0) ? S_OUT : S_K0;
            S_K0:  if (r_dcnt == '0) n_state = S_K1;
            S_K1:  if (r_dcnt == '0) n_state = S_M10;
            S_M10: n_state = S_M11;
            S_M11: n_state = S_M12;
            S_M12: n_state = S_M13;
            S_M13: n_state = S_M14;
            S_M14: n_state = S_M15;
            S_M15: n_state = S_M16;
            S_M16: n_state = S_OUT;
            S_OUT: if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Intermediate values of the prediction and correction.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_meas  <= i_in_item.baro_altitude;
            r_accel <= i_in_item.measured_accel;
            r_elap  <= w_elapsed[15:0];
        end
        unique case (r_state)
            S_DT: begin
                r_dn   <= 21'(r_elap) * 21'(DT_REM) + 21'(DT_BIAS);
                r_dint <= 31'(r_elap) * 31'(DT_WHOLE);
            end
            S_DT2: r_dt <= {1'b0, r_dint} + {17'd0, w_dprod[42:28]};
            S_M2:  r_ad <= sat32(w_mr);
            S_M3: begin
                r_acc <= 64'(r_alt) + w_mr;
                r_vp  <= sat32(64'(r_vel) + 64'(r_ad));
            end
            S_M4:  r_ap <= sat32(r_acc + w_mr);
            S_M5:  r_acc <= 64'(r_cov[0]) + w_mr + w_qa;
            S_M6: begin
                r_p01 <= sat32(64'(r_cov[1]) + w_mr);
                r_p10 <= sat32(64'(r_cov[2]) + w_mr);
                r_t   <= sat32(w_mr);
            end
            S_M7: begin
                r_p11 <= sat32(64'(r_cov[3]) + w_qv);
                r_inn <= sat32(64'(r_meas) - 64'(r_ap));
            end
            S_M8:  r_p00 <= sat32(r_acc + w_mr);
            S_K0:  if (r_dcnt == '0) r_k0 <= gain_fix(r_dnum, r_p00[31]);
            S_K1:  if (r_dcnt == '0) r_k1 <= gain_fix(r_dnum, r_p10[31]);
            default: r_acc <= r_acc;
        endcase
    end

    // Configuration registers and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pna    <= RST_PNA;
            r_pnv    <= RST_PNV;
            r_mn     <= RST_MN;
            r_gap    <= RST_GAP;
            r_alt    <= '0;
            r_vel    <= '0;
            r_peak   <= '0;
            r_last   <= '0;
            r_cov[0] <= COV_ONE;
            r_cov[1] <= '0;
            r_cov[2] <= '0;
            r_cov[3] <= COV_ONE;
            r_seeded <= 1'b0;
            r_status <= ST_SEEDED;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PNA: r_pna <= i_cfg_data;
                    CFG_PNV: r_pnv <= i_cfg_data;
                    CFG_MN:  r_mn  <= i_cfg_data;
                    CFG_GAP: r_gap <= i_cfg_data[15:0];
                    default: r_gap <= r_gap;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        priority if (i_in_item.action) begin
                            r_alt    <= '0;
                            r_vel    <= '0;
                            r_peak   <= '0;
                            r_last   <= '0;
                            r_cov[0] <= COV_ONE;
                            r_cov[1] <= '0;
                            r_cov[2] <= '0;
                            r_cov[3] <= COV_ONE;
                            r_seeded <= 1'b0;
                            r_status <= ST_RESTART;
                        end else if (!r_seeded) begin
                            r_alt    <= i_in_item.baro_altitude;
                            r_vel    <= '0;
                            r_peak   <= i_in_item.baro_altitude;
                            r_last   <= i_in_item.sample_time_ms;
                            r_seeded <= 1'b1;
                            r_status <= ST_SEEDED;
                        end else if (w_elapsed == '0) begin
                            r_status <= ST_ZERO;
                        end else if (w_elapsed > {16'd0, r_gap}) begin
                            r_last   <= i_in_item.sample_time_ms;
                            r_status <= ST_GAP;
                        end else begin
                            r_last   <= i_in_item.sample_time_ms;
                        end
                    end
                end
                S_M9:  if (w_s <= 64'sd0) r_status <= ST_BADVAR;
                S_M11: r_alt <= sat32(64'(r_ap) + w_mr);
                S_M12: begin
                    r_vel <= sat32(64'(r_vp) + w_mr);
                    if (r_alt > r_peak) r_peak <= r_alt;
                end
                S_M13: r_cov[0] <= sat32(w_mr);
                S_M14: r_cov[1] <= sat32(w_mr);
                S_M15: r_cov[2] <= sat32(64'(r_p10) - w_mr);
                S_M16: begin
                    r_cov[3] <= sat32(64'(r_p11) - w_mr);
                    r_status <= ST_UPDATED;
                end
                default: r_seeded <= r_seeded;
            endcase
        end
    end

endmodule
